@@ rtl/swm_pkg.sv @@
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

    // Default sizing
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Width of the window size register
    localparam int CFG_WIDTH = 7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_RD,
        ST_FRONT_CMP,
        ST_BACK_RD,
        ST_BACK_CMP,
        ST_APPEND,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/swm_cmp.sv @@
// Shared signed greater-or-equal compare unit used for both age and value tests.
module swm_cmp #(
    parameter int W = 17
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_ge
);

    // a >= b, two's complement
    assign o_ge = (i_a >= i_b);

endmodule

@@ rtl/swm_store.sv @@
// Circular candidate store: one write port and one registered read port.
module swm_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 23
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sliding_window_maximum_top.sv @@
// Top level of the sliding window maximum block: sequencer, counters and output word.
//
// Usage:
//   Slave stream s_axis carries one sample per word: tdata holds the signed
//   sample, tuser[0] marks the first sample of a new sequence, which clears
//   the candidate store and the counters before the sample is taken.
//   Master stream m_axis carries the window maximum, one word per input word
//   once window_size samples of the current sequence have arrived.
//   The cfg channel writes window_size (0 acts as 1, above MAX_WINDOW acts
//   as MAX_WINDOW); write it only while the block is idle.
// Operation:
//   The sequencer steps one store read port and one shared compare unit.
//   Per word it reads the front candidate and pops it while it has aged
//   out, reads back candidates and pops those the sample dominates, then
//   appends the sample and loads any due result in ST_EMIT; s_axis_tready returns the cycle after.
// Reset and stall:
//   Reset clears the counters, sets window_size to 1 and empties the store.
//   While the receiver stalls, the output word holds and the next input word
//   is still taken and processed; it waits only to load its own result.
module sliding_window_maximum_top #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // [SW-1:0] sample_value
    input  logic                                  s_axis_tuser,   // [0] start_of_sequence
    // Output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,   // [SW-1:0] window_max
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]         i_cfg_data      // window_size
);

    import swm_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int NW   = $clog2(MAX_WINDOW + 1);
    localparam int PW   = $clog2(MAX_WINDOW) + 1;
    localparam int EW   = PW + SW;
    localparam int CMPW = (SW > PW + 1) ? SW : PW + 1;
    localparam int WCW  = (NW > CFG_WIDTH) ? NW : CFG_WIDTH;

    // Registers
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [NW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_pos, n_pos;
    logic [NW-1:0]   r_fill, n_fill;
    logic [CFG_WIDTH-1:0] r_win;
    logic [SW-1:0]   r_x, n_x;
    logic            r_front_new, n_front_new;
    logic            r_out_valid, n_out_valid;
    logic [SW-1:0]   r_out_data, n_out_data;

    // Store and compare connections
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;
    logic [SW-1:0]   rd_value;
    logic [PW-1:0]   rd_pos;
    logic signed [CMPW-1:0] cmp_a, cmp_b;
    logic            cmp_ge;

    // Derived values
    logic [NW-1:0]   eff_win;
    logic [PW-1:0]   age;
    logic [AW-1:0]   head_inc, back_addr, app_addr, head_a;
    logic [NW-1:0]   cnt_a;
    logic            store_full;
    logic            accept_in;
    logic            need_out;
    logic            out_free;

    // Circular address: base + offset, offset at most the depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [NW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(off);
        if (sum >= (AW+1)'(MAX_WINDOW)) begin
            sum = sum - (AW+1)'(MAX_WINDOW);
        end
        return sum[AW-1:0];
    endfunction

    // Effective window: 0 acts as 1, clamp at the store depth
    always_comb begin
        if (r_win == '0) begin
            eff_win = NW'(1);
        end else if (WCW'(r_win) > WCW'(MAX_WINDOW)) begin
            eff_win = NW'(MAX_WINDOW);
        end else begin
            eff_win = NW'(r_win);
        end
    end

    assign rd_value   = mem_rdata[SW-1:0];
    assign rd_pos     = mem_rdata[EW-1:SW];
    assign age        = r_pos - rd_pos;
    assign head_inc   = wrap_add(r_head, NW'(1));
    assign back_addr  = wrap_add(r_head, r_count - NW'(1));
    assign store_full = (r_count >= NW'(MAX_WINDOW));
    assign head_a     = store_full ? head_inc : r_head;
    assign cnt_a      = store_full ? (r_count - NW'(1)) : r_count;
    assign app_addr   = wrap_add(head_a, cnt_a);
    assign accept_in  = s_axis_tvalid && s_axis_tready;
    assign need_out   = (r_fill >= eff_win);
    assign out_free   = !r_out_valid || m_axis_tready;

    // Shared compare operands: age vs window at the front, sample vs candidate at the back
    always_comb begin
        if (r_state == ST_FRONT_CMP) begin
            cmp_a = CMPW'(age);
            cmp_b = CMPW'(eff_win);
        end else begin
            cmp_a = CMPW'($signed(r_x));
            cmp_b = CMPW'($signed(rd_value));
        end
    end

    swm_cmp #(
        .W (CMPW)
    ) u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_ge (cmp_ge)
    );

    swm_store #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW),
        .DW    (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: begin
                n_state = (r_count == '0) ? ST_APPEND : ST_FRONT_CMP;
            end
            ST_FRONT_CMP: begin
                n_state = cmp_ge ? ST_FRONT_RD : ST_BACK_RD;
            end
            ST_BACK_RD: begin
                n_state = (r_count == '0) ? ST_APPEND : ST_BACK_CMP;
            end
            ST_BACK_CMP: begin
                n_state = cmp_ge ? ST_BACK_RD : ST_APPEND;
            end
            ST_APPEND: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!need_out || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_x         = r_x;
        n_front_new = r_front_new;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = app_addr;
        mem_wdata   = {r_pos, r_x};
        mem_re      = 1'b0;
        mem_raddr   = r_head;
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_x = s_axis_tdata[SW-1:0];
                    if (s_axis_tuser) begin
                        n_count = '0;
                        n_pos   = '0;
                        n_fill  = '0;
                    end
                end
            end
            ST_FRONT_RD: begin
                mem_re = 1'b1;
            end
            ST_FRONT_CMP: begin
                // aged out: pop the front
                if (cmp_ge) begin
                    n_head  = head_inc;
                    n_count = r_count - NW'(1);
                end
            end
            ST_BACK_RD: begin
                mem_re    = 1'b1;
                mem_raddr = back_addr;
            end
            ST_BACK_CMP: begin
                // dominated by the new sample: pop the back
                if (cmp_ge) begin
                    n_count = r_count - NW'(1);
                end
            end
            ST_APPEND: begin
                mem_we      = 1'b1;
                mem_re      = 1'b1;
                mem_raddr   = head_a;
                n_head      = head_a;
                n_count     = cnt_a + NW'(1);
                n_pos       = r_pos + PW'(1);
                n_front_new = (cnt_a == '0);
                if (r_fill < NW'(MAX_WINDOW)) begin
                    n_fill = r_fill + NW'(1);
                end
            end
            ST_EMIT: begin
                if (need_out && out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_front_new ? r_x : rd_value;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_win       <= CFG_WIDTH'(1);
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_win <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_front_new <= n_front_new;
        r_out_data  <= n_out_data;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TW'(r_out_data);
    assign o_cfg_ready   = 1'b1;

`ifndef NO_ASSERTIONS
    // Candidate count never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_WINDOW))
        else $error("candidate count above store depth");

    // Fill count saturates at the store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NW'(MAX_WINDOW))
        else $error("fill count above store depth");

    // Head pointer stays inside the store
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(MAX_WINDOW) || MAX_WINDOW == (1 << AW))
        else $error("head pointer outside store");

    // A start word clears the fill count
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in && s_axis_tuser |=> r_fill == '0)
        else $error("start of sequence did not clear fill count");

    // After an append the store holds at least the new sample
    a_append_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_APPEND |=> r_count != '0)
        else $error("store empty after append");
`endif

endmodule

@@ tb/sliding_window_maximum_checker.sv @@
// Checker for the sliding window maximum block: watches the streams, predicts and compares.
module sliding_window_maximum_checker #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int DATA_WIDTH   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [DATA_WIDTH-1:0]         i_s_tdata,    // [SW-1:0] sample_value
    input  logic                          i_s_tuser,    // [0] start_of_sequence
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [DATA_WIDTH-1:0]         i_m_tdata,    // [SW-1:0] window_max
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);

    // Predictor state: candidates hold strictly falling values, oldest first
    logic signed [SAMPLE_WIDTH-1:0] cand_val [MAX_WINDOW];
    int unsigned                    cand_pos [MAX_WINDOW];
    int unsigned                    cand_cnt;
    int unsigned                    next_pos;
    int unsigned                    seq_fill;
    logic [swm_pkg::CFG_WIDTH-1:0]  win_reg;

    // Window maxima still to come out of the block
    logic signed [SAMPLE_WIDTH-1:0] max_q [$];

    int pending_r = 0;
    int fail_n    = 0;

    logic signed [SAMPLE_WIDTH-1:0] want_max;
    logic signed [SAMPLE_WIDTH-1:0] got_max;
    logic signed [SAMPLE_WIDTH-1:0] new_max;
    bit                             new_emit;

    assign o_pending    = pending_r;
    assign o_fail_count = fail_n;

    // Drop the oldest candidate
    task automatic drop_oldest();
        int k;
        if (cand_cnt != 0) begin
            for (k = 0; k + 1 < int'(cand_cnt); k++) begin
                cand_val[k] = cand_val[k+1];
                cand_pos[k] = cand_pos[k+1];
            end
            cand_cnt--;
        end
    endtask

    // One sample into the candidate store; emit is set once the window is full
    task automatic predict_max(input logic signed [SAMPLE_WIDTH-1:0] x, input logic sos,
                               output bit emit, output logic signed [SAMPLE_WIDTH-1:0] mx);
        int unsigned w;
        // zero acts as one, oversize acts as the largest window
        if (win_reg == '0)
            w = 1;
        else if (int'(win_reg) > MAX_WINDOW)
            w = MAX_WINDOW;
        else
            w = int'(win_reg);
        if (sos) begin
            cand_cnt = 0;
            next_pos = 0;
            seq_fill = 0;
        end
        // aged-out front, possibly several after a window shrink
        while (cand_cnt != 0 && (next_pos - cand_pos[0]) >= w)
            drop_oldest();
        // dominated back entries, ties included
        while (cand_cnt != 0 && cand_val[cand_cnt-1] <= x)
            cand_cnt--;
        if (cand_cnt >= MAX_WINDOW)
            drop_oldest();
        cand_val[cand_cnt] = x;
        cand_pos[cand_cnt] = next_pos;
        cand_cnt++;
        next_pos++;
        if (seq_fill < MAX_WINDOW)
            seq_fill++;
        emit = (seq_fill >= w);
        mx   = cand_val[0];
    endtask

    // Result words are checked before the input word of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cand_cnt = 0;
            next_pos = 0;
            seq_fill = 0;
            win_reg  = 1;
            max_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_max = i_m_tdata[SAMPLE_WIDTH-1:0];
                if (max_q.size() == 0) begin
                    $display("%0t: window_max expected none, actual %0d", $time, got_max);
                    fail_n++;
                end else begin
                    want_max = max_q[0];
                    max_q.delete(0);
                    if (got_max !== want_max) begin
                        $display("%0t: window_max expected %0d, actual %0d",
                                 $time, want_max, got_max);
                        fail_n++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_max(i_s_tdata[SAMPLE_WIDTH-1:0], i_s_tuser, new_emit, new_max);
                if (new_emit)
                    max_q.insert(max_q.size(), new_max);
            end
            if (i_cfg_valid && i_cfg_ready)
                win_reg = i_cfg_data;
        end
        pending_r <= max_q.size();
    end

endmodule

@@ tb/sliding_window_maximum_top_test.sv @@
// Testbench top for the sliding window maximum block: clock, reset, stimulus and verdict.
module sliding_window_maximum_top_test;

    import swm_pkg::*;

    localparam int MAXW         = MAX_WINDOW_DEF;
    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int DW           = ((SW + 7) / 8) * 8;
    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_WAIT  = 200;    // idle wait after the drain, so the last word can finish
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_WORDS  = 96;

    // Sample shapes used by random sequences
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_NARROW,
        SHAPE_FALLING,
        SHAPE_RISING,
        SHAPE_EXTREME
    } t_shape;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    int chk_pending;
    int chk_fails;

    int send_pct = 0;
    int recv_pct = 0;
    logic hold_arm  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    sliding_window_maximum_top #(
        .MAX_WINDOW  (MAXW),
        .SAMPLE_WIDTH(SW)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    sliding_window_maximum_checker #(
        .MAX_WINDOW  (MAXW),
        .SAMPLE_WIDTH(SW)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (chk_pending),
        .o_fail_count(chk_fails)
    );

    // Receiver: random stalls, plus one long hold-off when armed
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("[sliding_window_maximum_top] ERROR");
        $finish;
    end

    // Offer one sample word, with a random gap ahead of it
    task automatic send_word(input logic [SW-1:0] v, input logic sos);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'(v);
        s_tuser  <= sos;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // Stop sending, wait for every expected maximum, then let the block finish
    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (chk_pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Write window_size while idle
    task automatic write_window(input int w);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_WIDTH'(w);
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One sequence of shaped samples; a stray start flag now and then breaks it
    task automatic run_sequence(input int len, input logic sos_first, input t_shape shape);
        int          i;
        int          step;
        logic [SW-1:0] base;
        logic [SW-1:0] v;
        logic          sos;
        base = SW'($urandom_range(65535));
        step = $urandom_range(1, 300);
        for (i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NARROW: begin
                    v = SW'($urandom_range(6)) - SW'(3);
                end
                SHAPE_FALLING: begin
                    v = base - SW'(i * step);
                end
                SHAPE_RISING: begin
                    v = base + SW'(i * step);
                end
                SHAPE_EXTREME: begin
                    case ($urandom_range(3))
                        0: v = {1'b0, {(SW-1){1'b1}}};
                        1: v = {1'b1, {(SW-1){1'b0}}};
                        2: v = '0;
                        default: v = '1;
                    endcase
                end
                default: begin
                    v = SW'($urandom_range(65535));
                end
            endcase
            sos = (i == 0) ? sos_first : ($urandom_range(99) < 2);
            send_word(v, sos);
        end
    endtask

    initial begin
        int   p;
        int   left;
        int   len;
        int   winsz [NUM_PHASES];
        logic first_sos;

        winsz = '{1, 0, 64, 127, 65, 8, 2, 3, 7, 16, 33, 63};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of one: every word is its own maximum
        send_word(16'h7FFF, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0001, 1'b0);

        // Window of four: ties, aging, extremes, falling tail
        write_window(4);
        send_word(16'd5, 1'b1);
        send_word(16'd5, 1'b0);
        send_word(16'd5, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'd7, 1'b0);
        repeat (4) send_word(16'h8000, 1'b0);
        send_word(16'd30, 1'b0);
        send_word(16'd20, 1'b0);
        send_word(16'd10, 1'b0);

        // Shrink mid-sequence: several front candidates age out at once
        write_window(1);
        send_word(-16'sd5, 1'b0);

        // Grow mid-sequence: nothing comes out until the fill catches up
        write_window(2);
        send_word(16'd1, 1'b1);
        send_word(16'd2, 1'b0);
        send_word(16'd3, 1'b0);
        write_window(5);
        send_word(16'd4, 1'b0);
        send_word(16'd5, 1'b0);
        send_word(16'd6, 1'b0);

        // Random phases, each with its own window and idling pattern
        for (p = 0; p < NUM_PHASES; p++) begin
            write_window(winsz[p]);
            case (p % 4)
                0: begin send_pct = 0;  recv_pct <= 0;  end
                1: begin send_pct = 45; recv_pct <= 0;  end
                2: begin send_pct = 0;  recv_pct <= 45; end
                default: begin send_pct = 6; recv_pct <= 6; end
            endcase
            // back pressure: receiver holds off while words keep coming
            if (p == 5) begin
                send_pct = 0;
                hold_arm <= 1'b1;
            end
            left = PHASE_WORDS;
            first_sos = ($urandom_range(1) == 1);
            while (left > 0) begin
                len = $urandom_range(1, 140);
                if (len > left)
                    len = left;
                run_sequence(len, first_sos, t_shape'($urandom_range(4)));
                first_sos = 1'b1;
                left -= len;
            end
        end

        settle();
        if (chk_pending != 0)
            $display("%0t: window_max expected %0d more words, actual none",
                     $time, chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("[sliding_window_maximum_top] OK");
        end else begin
            $display("[sliding_window_maximum_top] ERROR");
        end
        $finish;
    end

endmodule

@@ sliding_window_maximum_top.f @@
rtl/swm_pkg.sv
rtl/swm_cmp.sv
rtl/swm_store.sv
rtl/sliding_window_maximum_top.sv
tb/sliding_window_maximum_checker.sv
tb/sliding_window_maximum_top_test.sv
